>>> rtl/dpd_pkg.sv
// shared types and constants of the dle packet deframer
`default_nettype none

package dpd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 512;

    localparam int unsigned LEN_W = 10;
    localparam int unsigned CK_W  = 7;
    localparam int unsigned ST_W  = 3;

    // control characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_SO  = 8'h0E;
    localparam logic [7:0] CH_SI  = 8'h0F;
    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] CH_ESC = 8'h1B;

    // result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // packet end status
    localparam logic [ST_W-1:0] ST_OK    = 3'd0;
    localparam logic [ST_W-1:0] ST_CSUM  = 3'd1;
    localparam logic [ST_W-1:0] ST_SHORT = 3'd2;
    localparam logic [ST_W-1:0] ST_HDR   = 3'd3;
    localparam logic [ST_W-1:0] ST_MAL   = 3'd4;
    localparam logic [ST_W-1:0] ST_OVF   = 3'd5;

    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [7:0]       data_byte;
        logic [7:0]       repeat_count;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] payload_length;
        logic [CK_W-1:0]  checksum;
    } dpd_result_t;

endpackage

`default_nettype wire

>>> rtl/dle_packet_deframer_core.sv
// top level of the dle packet deframer: stream ports, input and result registers
//
// Input channel s_axis: one raw received byte per transfer in tdata, tlast
// marks the final byte of a received buffer. Output channel m_axis: one
// result per transfer; tuser is the result kind (data run or packet end),
// tdata carries the decoded byte and repeat count of a run, or the status,
// payload length and checksum of a packet end. Bytes that produce no result
// (header, escapes, bytes after the end) are absorbed silently.
// Throughput is one byte per cycle while m_axis does not stall: a byte goes
// into the input register, is decoded from there by the state update logic,
// and its result lands in the result register, from which m_axis offers it.
// When m_axis stalls, the result register holds, the input register fills and
// then s_axis_tready drops; nothing is dropped or reordered.
// Reset empties both registers and puts the deframer at the first header
// byte of a new buffer. The byte carrying tlast always restarts the deframer.
`default_nettype none

module dle_packet_deframer_core
    import dpd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] data_byte, [15:8] repeat_count, [18:16] status,
    // [28:19] payload_length, [35:29] checksum, [39:36] zero
    output logic [39:0]      m_axis_tdata,
    output logic [0:0]       m_axis_tuser    // [0] result_kind
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic        out_valid_reg, out_valid_next;
    dpd_result_t out_reg;
    dpd_result_t step_result;
    logic        advance;
    logic        s_xfer;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    dpd_decode #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .result        (step_result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (m_axis_tready || !out_valid_reg)
        begin
            out_valid_next = advance && step_result.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eob_reg  <= s_axis_tlast;
        end
        if (advance && step_result.valid)
        begin
            out_reg <= step_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {4'd0, out_reg.checksum, out_reg.payload_length,
                            out_reg.status, out_reg.repeat_count, out_reg.data_byte};

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |=> in_valid_reg)
        else $error("pending byte lost while output stalled");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_DATA
        |-> out_reg.repeat_count != 8'd0 && out_reg.status == ST_OK)
        else $error("data run with zero count or status");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_END && out_reg.status != ST_OK
        |-> out_reg.payload_length == '0 && out_reg.checksum == '0)
        else $error("error end carries length or checksum");

endmodule

`default_nettype wire

>>> rtl/dpd_decode.sv
// deframer state and per-byte decode step
`default_nettype none

module dpd_decode
    import dpd_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        end_of_buffer,
    output dpd_result_t      result
);

    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned SUM_W = $clog2(MAX_PAYLOAD + 256);

    localparam logic [2:0] PH_BODY   = 3'd0;
    localparam logic [2:0] PH_ESCAPE = 3'd1;
    localparam logic [2:0] PH_COUNT  = 3'd2;
    localparam logic [2:0] PH_CNTESC = 3'd3;
    localparam logic [2:0] PH_LRC    = 3'd4;
    localparam logic [2:0] PH_IDLE   = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic             shift_reg, shift_next;
    logic [7:0]       last_reg, last_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       sum_reg, sum_next;
    logic [2:0]       index_reg, index_next;
    logic             hdr_bad_reg, hdr_bad_next;

    logic [7:0]       sbit;
    logic [7:0]       dbyte;
    logic [7:0]       dcount;
    logic [7:0]       run;
    logic             is_run;
    logic             err_v;
    logic [ST_W-1:0]  err_code;
    logic             have_end;
    logic             have_data;
    logic [ST_W-1:0]  end_st;
    logic [LEN_W-1:0] end_len;
    logic [CK_W-1:0]  end_ck;
    logic [CK_W-1:0]  calc;
    logic [SUM_W-1:0] new_count;
    logic [CNT_W+LEN_W-1:0] count_wide;
    logic             restart;

    assign sbit       = shift_reg ? 8'h80 : 8'h00;
    assign calc       = {1'b1, sum_reg};
    assign count_wide = (CNT_W + LEN_W)'(count_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        index_next   = index_reg;
        hdr_bad_next = hdr_bad_reg;
        result       = '0;
        dbyte        = '0;
        dcount       = '0;
        run          = '0;
        is_run       = 1'b0;
        err_v        = 1'b0;
        err_code     = ST_OK;
        have_end     = 1'b0;
        have_data    = 1'b0;
        end_st       = ST_OK;
        end_len      = '0;
        end_ck       = '0;
        new_count    = '0;
        restart      = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            restart = end_of_buffer;
        end
        else
        begin
            if (index_reg < 3'd4)
            begin
                index_next = index_reg + 3'd1;
            end
            if (phase_reg != PH_LRC)
            begin
                sum_next = sum_reg + rx_byte[5:0];
            end
            if ((index_reg == 3'd0 && rx_byte != CH_DLE) ||
                (index_reg == 3'd1 && rx_byte != CH_STX))
            begin
                hdr_bad_next = 1'b1;
            end

            if (end_of_buffer && index_reg < 3'd4)
            begin
                result.valid  = 1'b1;
                result.kind   = KIND_END;
                result.status = ST_SHORT;
            end
            else if (index_reg < 3'd3)
            begin
                // header and command bytes only feed the checksum and the header check
            end
            else if (hdr_bad_next)
            begin
                if (index_reg >= 3'd4)
                begin
                    result.valid  = 1'b1;
                    result.kind   = KIND_END;
                    result.status = ST_HDR;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (rx_byte == CH_DLE)
                        begin
                            phase_next = PH_ESCAPE;
                        end
                        else
                        begin
                            dbyte  = rx_byte | sbit;
                            dcount = 8'd1;
                        end
                    end
                    PH_ESCAPE:
                    begin
                        phase_next = PH_BODY;
                        case (rx_byte)
                            CH_SI:  shift_next = 1'b1;
                            CH_SO:  shift_next = 1'b0;
                            CH_DLE:
                            begin
                                dbyte  = CH_DLE | sbit;
                                dcount = 8'd1;
                            end
                            CH_CAN:
                            begin
                                dbyte  = CH_ESC | sbit;
                                dcount = 8'd1;
                            end
                            CH_VT:  phase_next = PH_COUNT;
                            CH_ETX: phase_next = PH_LRC;
                            default:
                            begin
                                err_v    = 1'b1;
                                err_code = ST_MAL;
                            end
                        endcase
                    end
                    PH_COUNT:
                    begin
                        if (rx_byte == CH_DLE)
                        begin
                            phase_next = PH_CNTESC;
                        end
                        else
                        begin
                            run    = rx_byte;
                            is_run = 1'b1;
                        end
                    end
                    PH_CNTESC:
                    begin
                        if (rx_byte == CH_DLE)
                        begin
                            run    = CH_DLE;
                            is_run = 1'b1;
                        end
                        else if (rx_byte == CH_CAN)
                        begin
                            run    = CH_ESC;
                            is_run = 1'b1;
                        end
                        else
                        begin
                            err_v    = 1'b1;
                            err_code = ST_MAL;
                        end
                    end
                    default:
                    begin
                        // received lrc byte
                        have_end = 1'b1;
                        if ({1'b0, calc} == rx_byte)
                        begin
                            end_st  = ST_OK;
                            end_len = count_wide[LEN_W-1:0];
                            end_ck  = calc;
                        end
                        else
                        begin
                            end_st = ST_CSUM;
                        end
                    end
                endcase

                if (is_run)
                begin
                    phase_next = PH_BODY;
                    if (run != 8'd0)
                    begin
                        if (count_reg == '0)
                        begin
                            err_v    = 1'b1;
                            err_code = ST_MAL;
                        end
                        else
                        begin
                            dbyte  = last_reg;
                            dcount = run;
                        end
                    end
                end

                new_count = SUM_W'(count_reg) + SUM_W'(dcount);
                if (!err_v && dcount != 8'd0)
                begin
                    if (new_count > SUM_W'(MAX_PAYLOAD))
                    begin
                        err_v    = 1'b1;
                        err_code = ST_OVF;
                    end
                    else
                    begin
                        have_data  = 1'b1;
                        count_next = new_count[CNT_W-1:0];
                        if (!is_run)
                        begin
                            last_next = dbyte;
                        end
                    end
                end

                if (err_v)
                begin
                    result.valid  = 1'b1;
                    result.kind   = KIND_END;
                    result.status = err_code;
                end
                else if (have_end)
                begin
                    result.valid          = 1'b1;
                    result.kind           = KIND_END;
                    result.status         = end_st;
                    result.payload_length = end_len;
                    result.checksum       = end_ck;
                end
                else if (end_of_buffer)
                begin
                    result.valid  = 1'b1;
                    result.kind   = KIND_END;
                    result.status = ST_MAL;
                end
                else if (have_data)
                begin
                    result.valid        = 1'b1;
                    result.kind         = KIND_DATA;
                    result.data_byte    = dbyte;
                    result.repeat_count = dcount;
                end
            end

            // after a packet end, skip to the end of the buffer
            if (result.valid && result.kind == KIND_END)
            begin
                if (end_of_buffer)
                begin
                    restart = 1'b1;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
        end

        if (restart)
        begin
            phase_next   = PH_BODY;
            shift_next   = 1'b0;
            last_next    = '0;
            count_next   = '0;
            sum_next     = '0;
            index_next   = '0;
            hdr_bad_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BODY;
            shift_reg   <= 1'b0;
            last_reg    <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            index_reg   <= '0;
            hdr_bad_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            shift_reg   <= shift_next;
            last_reg    <= last_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            index_reg   <= index_next;
            hdr_bad_reg <= hdr_bad_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(count_reg) <= SUM_W'(MAX_PAYLOAD))
        else $error("payload count past maximum");

    a_index_sat: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= 3'd4)
        else $error("byte index past saturation");

    a_data_grows: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.valid && result.kind == KIND_DATA && !end_of_buffer
        |=> count_reg == $past(count_reg) + CNT_W'($past(result.repeat_count)))
        else $error("payload count does not track emitted data");

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench of the dle packet deframer core with a byte-level predictor
`default_nettype none

module tb;
    import dpd_pkg::*;

    localparam int unsigned ITEM_TARGET = 1900;
    localparam int unsigned CALM_FROM   = 1600;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned QUIET_LIMIT = 2000;

    typedef enum logic [2:0] {
        PH_BODY,
        PH_ESCAPE,
        PH_COUNT,
        PH_CNTESC,
        PH_LRC,
        PH_IDLE
    } deframe_phase_e;

    typedef struct {
        logic             kind;
        logic [7:0]       data_byte;
        logic [7:0]       repeat_count;
        logic [ST_W-1:0]  status;
        logic [LEN_W-1:0] payload_length;
        logic [CK_W-1:0]  checksum;
    } frame_result_t;

    class deframer_scoreboard;
        deframe_phase_e phase;
        bit             shift_on;
        logic [7:0]     last_char;
        int unsigned    payload_count;
        logic [5:0]     running_sum;
        int unsigned    byte_index;
        bit             header_bad;
        frame_result_t  runs_and_ends[$];
        int unsigned    errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase         = PH_BODY;
            shift_on      = 1'b0;
            last_char     = 8'h00;
            payload_count = 0;
            running_sum   = 6'd0;
            byte_index    = 0;
            header_bad    = 1'b0;
        endfunction

        function int unsigned pending();
            return runs_and_ends.size();
        endfunction

        function void push_end(logic [ST_W-1:0] st, logic [LEN_W-1:0] len,
                               logic [CK_W-1:0] ck);
            frame_result_t r;
            r.kind           = KIND_END;
            r.data_byte      = 8'h00;
            r.repeat_count   = 8'h00;
            r.status         = st;
            r.payload_length = len;
            r.checksum       = ck;
            runs_and_ends.push_back(r);
        endfunction

        // predicts what one accepted byte transfer produces
        function void decode_byte(logic [7:0] b, logic eob);
            int unsigned     idx;
            int unsigned     run;
            int unsigned     dcount;
            bit              is_run;
            bit              have_err;
            bit              have_end;
            bit              have_data;
            logic [ST_W-1:0] err_st;
            logic [ST_W-1:0] end_st;
            int unsigned     end_len;
            logic [CK_W-1:0] end_ck;
            logic [CK_W-1:0] calc;
            logic [7:0]      dbyte;
            logic [7:0]      sbit;
            frame_result_t   r;

            run       = 0;
            dcount    = 0;
            is_run    = 1'b0;
            have_err  = 1'b0;
            have_end  = 1'b0;
            have_data = 1'b0;
            err_st    = ST_OK;
            end_st    = ST_OK;
            end_len   = 0;
            end_ck    = '0;
            dbyte     = 8'h00;

            if (phase == PH_IDLE)
            begin
                if (eob)
                    restart();
                return;
            end

            idx = byte_index;
            if (byte_index < 4)
                byte_index++;
            if (phase != PH_LRC)
                running_sum = running_sum + b[5:0];
            if (idx == 0 && b != CH_DLE)
                header_bad = 1'b1;
            if (idx == 1 && b != CH_STX)
                header_bad = 1'b1;

            // short buffer wins over everything
            if (eob && idx < 4)
            begin
                push_end(ST_SHORT, '0, '0);
                restart();
                return;
            end
            if (idx < 3)
                return;
            if (header_bad)
            begin
                if (idx >= 4)
                begin
                    push_end(ST_HDR, '0, '0);
                    if (eob)
                        restart();
                    else
                        phase = PH_IDLE;
                end
                return;
            end

            sbit = shift_on ? 8'h80 : 8'h00;
            case (phase)
                PH_BODY:
                begin
                    if (b == CH_DLE)
                        phase = PH_ESCAPE;
                    else
                    begin
                        dbyte  = b | sbit;
                        dcount = 1;
                    end
                end
                PH_ESCAPE:
                begin
                    phase = PH_BODY;
                    if (b == CH_SI)
                        shift_on = 1'b1;
                    else if (b == CH_SO)
                        shift_on = 1'b0;
                    else if (b == CH_DLE)
                    begin
                        dbyte  = CH_DLE | sbit;
                        dcount = 1;
                    end
                    else if (b == CH_CAN)
                    begin
                        dbyte  = CH_ESC | sbit;
                        dcount = 1;
                    end
                    else if (b == CH_VT)
                        phase = PH_COUNT;
                    else if (b == CH_ETX)
                        phase = PH_LRC;
                    else
                    begin
                        have_err = 1'b1;
                        err_st   = ST_MAL;
                    end
                end
                PH_COUNT:
                begin
                    if (b == CH_DLE)
                        phase = PH_CNTESC;
                    else
                    begin
                        run    = b;
                        is_run = 1'b1;
                    end
                end
                PH_CNTESC:
                begin
                    if (b == CH_DLE)
                    begin
                        run    = CH_DLE;
                        is_run = 1'b1;
                    end
                    else if (b == CH_CAN)
                    begin
                        run    = CH_ESC;
                        is_run = 1'b1;
                    end
                    else
                    begin
                        have_err = 1'b1;
                        err_st   = ST_MAL;
                    end
                end
                default:
                begin
                    calc     = {1'b1, running_sum};
                    have_end = 1'b1;
                    if ({1'b0, calc} == b)
                    begin
                        end_st  = ST_OK;
                        end_len = payload_count;
                        end_ck  = calc;
                    end
                    else
                        end_st = ST_CSUM;
                end
            endcase

            if (is_run)
            begin
                phase = PH_BODY;
                if (run != 0)
                begin
                    // a nonzero repeat needs an earlier payload byte
                    if (payload_count == 0)
                    begin
                        have_err = 1'b1;
                        err_st   = ST_MAL;
                    end
                    else
                    begin
                        dbyte  = last_char;
                        dcount = run;
                    end
                end
            end
            if (!have_err && dcount != 0)
            begin
                if (payload_count + dcount > MAX_PAYLOAD_DEF)
                begin
                    have_err = 1'b1;
                    err_st   = ST_OVF;
                end
                else
                begin
                    have_data = 1'b1;
                    if (!is_run)
                        last_char = dbyte;
                    payload_count += dcount;
                end
            end

            if (have_err)
                push_end(err_st, '0, '0);
            else if (have_end)
                push_end(end_st, LEN_W'(end_len), end_ck);
            else if (eob)
                push_end(ST_MAL, '0, '0);
            else
            begin
                if (have_data)
                begin
                    r.kind           = KIND_DATA;
                    r.data_byte      = dbyte;
                    r.repeat_count   = 8'(dcount);
                    r.status         = ST_OK;
                    r.payload_length = '0;
                    r.checksum       = '0;
                    runs_and_ends.push_back(r);
                end
                return;
            end
            if (eob)
                restart();
            else
                phase = PH_IDLE;
        endfunction

        function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic kind, logic [39:0] tdata);
            frame_result_t want;
            if (runs_and_ends.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, expected none, actual kind %0h data %h",
                         $time, kind, tdata);
                errors++;
                return;
            end
            want = runs_and_ends.pop_front();
            compare_field("result_kind", 16'(want.kind), 16'(kind));
            compare_field("data_byte", 16'(want.data_byte), 16'(tdata[7:0]));
            compare_field("repeat_count", 16'(want.repeat_count), 16'(tdata[15:8]));
            compare_field("status", 16'(want.status), 16'(tdata[18:16]));
            compare_field("payload_length", 16'(want.payload_length), 16'(tdata[28:19]));
            compare_field("checksum", 16'(want.checksum), 16'(tdata[35:29]));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic        s_axis_tlast  = 1'b0;    // end_of_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;            // [7:0] data_byte, [15:8] repeat_count,
                                          // [18:16] status, [28:19] payload_length,
                                          // [35:29] checksum
    logic [0:0]  m_axis_tuser;            // [0] result_kind

    deframer_scoreboard sb;
    logic [7:0]  frame_q[$];
    int unsigned items_sent = 0;
    bit          idle_on    = 1'b1;
    bit          stall_on   = 1'b1;
    bit          hold_req   = 1'b0;

    dle_packet_deframer_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == CH_DLE);
        return b;
    endfunction

    function automatic void add_header();
        frame_q.push_back(CH_DLE);
        frame_q.push_back(CH_STX);
        frame_q.push_back(8'($urandom));
    endfunction

    // repeat count, escaped where it equals DLE and at random where it equals ESC
    function automatic void add_repeat(int unsigned n);
        frame_q.push_back(CH_DLE);
        frame_q.push_back(CH_VT);
        if (n == CH_DLE)
        begin
            frame_q.push_back(CH_DLE);
            frame_q.push_back(CH_DLE);
        end
        else if (n == CH_ESC && $urandom_range(0, 1) == 0)
        begin
            frame_q.push_back(CH_DLE);
            frame_q.push_back(CH_CAN);
        end
        else
            frame_q.push_back(8'(n));
    endfunction

    function automatic void add_op();
        int unsigned r;
        int unsigned c;
        r = $urandom_range(0, 19);
        if (r < 10)
            frame_q.push_back(plain_byte());
        else if (r < 15)
        begin
            frame_q.push_back(CH_DLE);
            case (r)
                10:      frame_q.push_back(CH_DLE);
                11:      frame_q.push_back(CH_CAN);
                14:      frame_q.push_back(CH_SO);
                default: frame_q.push_back(CH_SI);
            endcase
        end
        else
        begin
            c = $urandom_range(0, 9);
            if (c < 6)
                add_repeat($urandom_range(0, 6));
            else if (c == 6)
                add_repeat(CH_DLE);
            else if (c == 7)
                add_repeat(CH_ESC);
            else
                add_repeat($urandom_range(0, 255));
        end
    endfunction

    function automatic void close_frame(bit good);
        logic [5:0] sum;
        logic [7:0] lrc;
        frame_q.push_back(CH_DLE);
        frame_q.push_back(CH_ETX);
        sum = 6'd0;
        foreach (frame_q[i])
            sum = sum + frame_q[i][5:0];
        lrc = {2'b01, sum};
        if (!good)
            lrc = lrc ^ 8'($urandom_range(1, 255));
        frame_q.push_back(lrc);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_last, input bit calm);
        if (idle_on && !calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.decode_byte(b, is_last);
        items_sent++;
    endtask

    task automatic send_frame();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1, calm);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // result sink: random stalls, calm stretches and a long hold on request
    initial
    begin
        int unsigned calm_left;
        calm_left = 0;
        wait (rst_n);
        forever
        begin
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(20, 80);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (stall_on && calm_left == 0 && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser[0], m_axis_tdata);
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int unsigned frames;
        int unsigned r;
        int unsigned n_ops;
        int unsigned cut;
        int unsigned hdr_pos;
        logic [7:0]  b;

        sb = new();
        frames = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every escape, shift on and off, zero repeat, escaped repeat count
        frame_q = '{CH_DLE, CH_STX, 8'h00, 8'hFF, CH_DLE, CH_SI, 8'h7F, CH_DLE, CH_DLE,
                    CH_DLE, CH_CAN, CH_DLE, CH_SO, 8'h80, CH_DLE, CH_VT, 8'h00,
                    CH_DLE, CH_VT, CH_DLE, CH_DLE};
        close_frame(1'b1);
        send_frame();
        frame_q = '{CH_DLE};
        send_frame();

        while (items_sent < ITEM_TARGET)
        begin
            frame_q.delete();
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                add_header();
                if (r >= 60 && r < 65)
                begin
                    // climb to the payload limit, then stay on it or cross it
                    frame_q.push_back(plain_byte());
                    add_repeat(255);
                    add_repeat(255);
                    case ($urandom_range(0, 2))
                        0: add_repeat(1);
                        1:
                        begin
                            add_repeat(1);
                            frame_q.push_back(plain_byte());
                        end
                        default: add_repeat($urandom_range(2, 255));
                    endcase
                end
                else
                begin
                    if (r >= 55 && r < 60)
                        add_repeat(r == 55 ? 0 : $urandom_range(1, 9));
                    n_ops = $urandom_range(0, 12);
                    for (int i = 0; i < n_ops; i++)
                    begin
                        if (i == 0)
                            frame_q.push_back(plain_byte());
                        else
                            add_op();
                    end
                end
                if (r >= 65 && r < 68)
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_SI || b == CH_SO || b == CH_DLE || b == CH_CAN ||
                           b == CH_VT || b == CH_ETX);
                    frame_q.push_back(CH_DLE);
                    frame_q.push_back(b);
                    add_op();
                end
                if (r >= 68 && r < 70)
                begin
                    do
                        b = 8'($urandom);
                    while (b == CH_DLE || b == CH_CAN);
                    frame_q.push_back(CH_DLE);
                    frame_q.push_back(CH_VT);
                    frame_q.push_back(CH_DLE);
                    frame_q.push_back(b);
                    add_op();
                end
                close_frame(r < 50 || r >= 55);
                if (r >= 45 && r < 50)
                begin
                    hdr_pos = $urandom_range(0, 1);
                    frame_q[hdr_pos] = frame_q[hdr_pos] ^ 8'($urandom_range(1, 255));
                end
                if (r >= 70)
                begin
                    // buffer ends before the lrc
                    cut = $urandom_range(5, frame_q.size() - 1);
                    frame_q = frame_q[0:cut-1];
                end
                else if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
            end
            else if (r < 88)
            begin
                n_ops = $urandom_range(1, 4);
                for (int i = 0; i < n_ops; i++)
                begin
                    b = 8'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        b = (i == 0) ? CH_DLE : (i == 1) ? CH_STX : b;
                    frame_q.push_back(b);
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    add_header();
                repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
            end

            send_frame();
            frames++;
            if (frames == 8 || frames == 60)
                hold_req = 1'b1;
            if (frames == 20 || $urandom_range(0, 29) == 0)
                drain_results();
            if (items_sent > CALM_FROM)
            begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
